/* sv/b64d_pkg.sv */
// ============================================================================
// Base64 decoder package
// Shared types, character codes and the Base64 alphabet lookup.
// ============================================================================
package b64d_pkg;

   localparam int CHAR_W  = 8;
   localparam int SEXT_W  = 6;
   localparam int ACC_W   = 24;
   localparam int PHASE_W = 2;

   localparam logic [CHAR_W-1:0] CHAR_PAD   = 8'h3D; // '='
   localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
   localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CHAR_SLASH = 8'h2F;
   localparam logic [CHAR_W-1:0] CHAR_UC_A  = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_UC_Z  = 8'h5A;
   localparam logic [CHAR_W-1:0] CHAR_LC_A  = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_LC_Z  = 8'h7A;
   localparam logic [CHAR_W-1:0] CHAR_D0    = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_D9    = 8'h39;

   localparam logic [SEXT_W-1:0] SEXT_PLUS  = 6'd62;
   localparam logic [SEXT_W-1:0] SEXT_SLASH = 6'd63;

   localparam logic [PHASE_W-1:0] PHASE_FIRST  = 2'd0;
   localparam logic [PHASE_W-1:0] PHASE_SECOND = 2'd1;
   localparam logic [PHASE_W-1:0] PHASE_THIRD  = 2'd2;
   localparam logic [PHASE_W-1:0] PHASE_FOURTH = 2'd3;

   typedef struct packed {
      logic [PHASE_W-1:0] phase;
      logic [ACC_W-1:0]   acc;
      logic               pad_seen;
   } grp_state_type;

   localparam grp_state_type GRP_RESET = '{phase: PHASE_FIRST, acc: '0, pad_seen: 1'b0};

   // Six-bit value of a Base64 character; anything outside the alphabet is zero.
   function automatic logic [SEXT_W-1:0] sextet_of(input logic [CHAR_W-1:0] c);
      logic [CHAR_W-1:0] d;
      d = '0;
      if (c >= CHAR_UC_A && c <= CHAR_UC_Z) begin
         d = c - CHAR_UC_A;
      end else if (c >= CHAR_LC_A && c <= CHAR_LC_Z) begin
         d = c - CHAR_LC_A + 8'd26;
      end else if (c >= CHAR_D0 && c <= CHAR_D9) begin
         d = c - CHAR_D0 + 8'd52;
      end else if (c == CHAR_PLUS) begin
         d = {2'b00, SEXT_PLUS};
      end else if (c == CHAR_SLASH) begin
         d = {2'b00, SEXT_SLASH};
      end
      return d[SEXT_W-1:0];
   endfunction

endpackage

/* sv/b64d_step.sv */
// ============================================================================
// Base64 decoder group step
// Advances the four-character group state by one character and picks the
// decoded byte, if the character completes one.
// ============================================================================
module b64d_step
   import b64d_pkg::*;
(
   input  grp_state_type     cur,
   input  logic [CHAR_W-1:0] char_in,
   input  logic              last_char,
   output grp_state_type     nxt,
   output logic              emit,
   output logic [7:0]        byte_out
);

   logic [SEXT_W-1:0] sext;
   logic [ACC_W-1:0]  acc_sum;
   logic              is_pad;
   logic              is_brk;
   grp_state_type     upd;

   assign sext   = sextet_of(char_in);
   assign is_pad = (char_in == CHAR_PAD);
   assign is_brk = (char_in == CHAR_CR) || (char_in == CHAR_LF);

   always_comb begin
      upd      = cur;
      emit     = 1'b0;
      byte_out = '0;
      acc_sum  = '0;
      unique case (cur.phase)
         PHASE_FIRST: begin
            if (!is_brk) begin
               upd.acc      = {sext, 18'd0};
               upd.pad_seen = 1'b0;
               upd.phase    = PHASE_SECOND;
            end
         end
         PHASE_SECOND: begin
            acc_sum   = cur.acc + {6'd0, sext, 12'd0};
            upd.acc   = acc_sum;
            emit      = 1'b1;
            byte_out  = acc_sum[23:16];
            upd.phase = PHASE_THIRD;
         end
         PHASE_THIRD: begin
            acc_sum = cur.acc + {12'd0, sext, 6'd0};
            if (is_pad) begin
               upd.pad_seen = 1'b1;
            end else begin
               upd.acc  = acc_sum;
               emit     = 1'b1;
               byte_out = acc_sum[15:8];
            end
            upd.phase = PHASE_FOURTH;
         end
         default: begin
            acc_sum = cur.acc + {18'd0, sext};
            if (!cur.pad_seen && !is_pad) begin
               upd.acc  = acc_sum;
               emit     = 1'b1;
               byte_out = acc_sum[7:0];
            end
            upd.pad_seen = 1'b0;
            upd.phase    = PHASE_FIRST;
         end
      endcase
      nxt = last_char ? GRP_RESET : upd;
   end

endmodule

/* sv/base64_stream_decoder_core.sv */
// ============================================================================
// Base64 stream decoder core
// Decodes one Base64 character per transaction into zero or one data byte.
// ============================================================================
// Each accepted character is held in the input register, and the byte it
// produces then passes through the result register before rsp_valid rises.
// Throughput: one character per cycle while rsp_ready keeps the result
// register draining; the group state loop closes through the step logic.
// Reset: synchronous, active high; clears both stage valids and the group
// state (phase, accumulator and padding flag) to the start of a group.
module base64_stream_decoder_core
   import b64d_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [CHAR_W-1:0] req_char_in,
   input  logic              req_last_char,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [7:0]        rsp_byte_out
);

   // Input register stage. It holds one accepted character until the result
   // register can take whatever that character produces.
   logic              in_valid_ff;
   logic [CHAR_W-1:0] in_char_ff;
   logic              in_last_ff;

   // Group state, updated exactly when a character leaves the input stage.
   grp_state_type     grp_ff;
   grp_state_type     grp_in;

   // Result register.
   logic              out_valid_ff;
   logic [7:0]        out_byte_ff;

   logic              step_emit;
   logic [7:0]        step_byte;
   logic              advance;

   // A character may leave the input stage when the result register is
   // empty or is being drained in this same cycle. Characters that produce
   // no byte (line breaks between groups, padding) still leave and update the group state.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);

   // The input stage takes a new transaction whenever it is empty or its
   // current character moves on, so back-to-back transactions flow freely.
   assign req_ready = !in_valid_ff || advance;

   b64d_step u_step (
      .cur       (grp_ff),
      .char_in   (in_char_ff),
      .last_char (in_last_ff),
      .nxt       (grp_in),
      .emit      (step_emit),
      .byte_out  (step_byte)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_char_ff <= req_char_in;
         in_last_ff <= req_last_char;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grp_ff <= GRP_RESET;
      end else if (advance) begin
         grp_ff <= grp_in;
      end
   end

   // The result register is refilled on every advance; a character that
   // produces no byte leaves it empty, which frees it for the next one.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= step_emit;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && step_emit) begin
         out_byte_ff <= step_byte;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_byte_out = out_byte_ff;

endmodule
